[sv/tspu_pkg.sv]
// Shared types, widths and codes for the trapezoid speed profile unit.
package tspu_pkg;

   // Time base: phase lengths and elapsed counter width
   localparam int TIME_BITS = 16;

   // Fixed field widths
   localparam int MS_W   = 16;
   localparam int PEAK_W = 14;
   localparam int PCT_W  = 7;
   localparam int GAIN_W = 8;
   localparam int HEAD_W = 24;
   localparam int SPD_W  = 16;
   localparam int PH_W   = 2;
   localparam int CSR_W  = 3;

   // Shared multiplier / divider sizing
   localparam int DVS_W = (TIME_BITS > PCT_W) ? TIME_BITS : PCT_W;
   localparam int MUL_W = MS_W + DVS_W;
   localparam int DIV_W = (PEAK_W + TIME_BITS > MS_W + PCT_W) ?
                          (PEAK_W + TIME_BITS) : (MS_W + PCT_W);
   localparam int CNT_W = $clog2(DIV_W + 1);

   // Heading correction product and its floor-shifted result
   localparam int HPROD_W = HEAD_W + GAIN_W + 2;
   localparam int CORR_W  = HPROD_W - GAIN_W;
   localparam int SUM_W   = CORR_W + 1;

   localparam logic [TIME_BITS-1:0] TMAX    = '1;
   localparam logic [PCT_W-1:0]     PCT_DIV = PCT_W'(100);

   // Profile phases
   localparam logic [PH_W-1:0] PH_IDLE   = 2'd0;
   localparam logic [PH_W-1:0] PH_ACCEL  = 2'd1;
   localparam logic [PH_W-1:0] PH_CRUISE = 2'd2;
   localparam logic [PH_W-1:0] PH_DECEL  = 2'd3;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_TOTAL     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_PEAK      = 3'd1;
   localparam logic [CSR_W-1:0] CSR_ACC_PCT   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_DEC_PCT   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_MIN_ACC   = 3'd4;
   localparam logic [CSR_W-1:0] CSR_MIN_DEC   = 3'd5;
   localparam logic [CSR_W-1:0] CSR_GAIN      = 3'd6;
   localparam logic [CSR_W-1:0] CSR_REVERSE   = 3'd7;

   typedef struct packed {
      logic                     start_req;
      logic signed [HEAD_W-1:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [SPD_W-1:0] left_cmd;
      logic signed [SPD_W-1:0] right_cmd;
      logic [PH_W-1:0]         phase;
      logic                    done_res;
   } rsp_type;

   typedef struct packed {
      logic [MS_W-1:0]   total_time_ms;
      logic [PEAK_W-1:0] peak_speed;
      logic [PCT_W-1:0]  accel_percent;
      logic [PCT_W-1:0]  decel_percent;
      logic [MS_W-1:0]   min_accel_ms;
      logic [MS_W-1:0]   min_decel_ms;
      logic [GAIN_W-1:0] heading_gain;
      logic              reverse;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_sts_type;

endpackage

[sv/tspu_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module tspu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tspu_pkg::div_cmd_type cmd,
   output tspu_pkg::div_sts_type sts
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tspu_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [tspu_pkg::DIV_W-1:0]    num_ff, num_in;
   logic [tspu_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [tspu_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [tspu_pkg::DVS_W:0]      trial;
   logic                          fits;

   // Shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, num_ff[tspu_pkg::DIV_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = tspu_pkg::CNT_W'(tspu_pkg::DIV_W);
         num_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[tspu_pkg::DIV_W-2:0], fits};
         rem_in = fits ? tspu_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                       : trial[tspu_pkg::DVS_W-1:0];
         cnt_in = cnt_ff - tspu_pkg::CNT_W'(1);
         if (cnt_ff == tspu_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = num_ff;

endmodule

[sv/tspu_csr.sv]
// Configuration register bank of the speed profile unit.
module tspu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tspu_pkg::CSR_W-1:0]  csr_idx,
   input  logic [tspu_pkg::MS_W-1:0]   csr_wdata,
   output tspu_pkg::cfg_type           cfg
);

   tspu_pkg::cfg_type cfg_ff, cfg_in;

   // Decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx)
            tspu_pkg::CSR_TOTAL:   cfg_in.total_time_ms = csr_wdata;
            tspu_pkg::CSR_PEAK:    cfg_in.peak_speed    = csr_wdata[tspu_pkg::PEAK_W-1:0];
            tspu_pkg::CSR_ACC_PCT: cfg_in.accel_percent = csr_wdata[tspu_pkg::PCT_W-1:0];
            tspu_pkg::CSR_DEC_PCT: cfg_in.decel_percent = csr_wdata[tspu_pkg::PCT_W-1:0];
            tspu_pkg::CSR_MIN_ACC: cfg_in.min_accel_ms  = csr_wdata;
            tspu_pkg::CSR_MIN_DEC: cfg_in.min_decel_ms  = csr_wdata;
            tspu_pkg::CSR_GAIN:    cfg_in.heading_gain  = csr_wdata[tspu_pkg::GAIN_W-1:0];
            tspu_pkg::CSR_REVERSE: cfg_in.reverse       = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_time_ms <= '0;
         cfg_ff.peak_speed    <= '0;
         cfg_ff.accel_percent <= tspu_pkg::PCT_W'(30);
         cfg_ff.decel_percent <= tspu_pkg::PCT_W'(30);
         cfg_ff.min_accel_ms  <= tspu_pkg::MS_W'(300);
         cfg_ff.min_decel_ms  <= tspu_pkg::MS_W'(300);
         cfg_ff.heading_gain  <= '0;
         cfg_ff.reverse       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/trapezoid_speed_profile_unit.sv]
// Top level of the trapezoid speed profile unit: sequencer, datapath, result register.
//
// Usage: write the registers over the csr_ port while the unit is idle, then send a
// start beat (start_req = 1) carrying the current heading, followed by one tick beat
// (start_req = 0) per millisecond. Every request beat yields exactly one response
// beat with the left/right wheel speeds, the phase and the done flag.
// A start beat runs two divisions through the shared divider to size the accel and
// decel phases. A tick in accel or decel runs one ramp division; a tick in cruise,
// idle or after the move finishes runs no division. The shared restoring divider
// produces one quotient bit per cycle. req_ready is high only while the sequencer
// is idle, one item at a time, so the next beat can be taken in the same cycle the
// response appears.
// The response sits in an output register, so the next request can be taken while
// a finished response still waits; if the receiver stalls longer, the sequencer
// holds its next result until the output register frees up.
// Synchronous reset returns registers to their defaults, clears the profile to
// idle and drops rsp_valid. No clearing pass is needed.
module trapezoid_speed_profile_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tspu_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tspu_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [tspu_pkg::CSR_W-1:0]  csr_idx,
   input  logic [tspu_pkg::MS_W-1:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADV    = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_LAUNCH = 3'd3;
   localparam logic [2:0] S_WAIT   = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   localparam logic [1:0] JOB_ACC  = 2'd0;
   localparam logic [1:0] JOB_DEC  = 2'd1;
   localparam logic [1:0] JOB_RAMP = 2'd2;

   tspu_pkg::cfg_type     cfg;
   tspu_pkg::div_cmd_type div_cmd;
   tspu_pkg::div_sts_type div_sts;

   logic [2:0]                          state_ff, state_in;
   logic [1:0]                          job_ff, job_in;
   logic signed [tspu_pkg::HEAD_W-1:0]  hd_ff, hd_in;
   logic signed [tspu_pkg::HEAD_W-1:0]  base_hd_ff, base_hd_in;
   logic [tspu_pkg::PH_W-1:0]           phase_ff, phase_in;
   logic [tspu_pkg::TIME_BITS-1:0]      elapsed_ff, elapsed_in;
   logic                                finished_ff, finished_in;
   logic [tspu_pkg::TIME_BITS-1:0]      acc_len_ff, acc_len_in;
   logic [tspu_pkg::TIME_BITS-1:0]      cru_len_ff, cru_len_in;
   logic [tspu_pkg::TIME_BITS-1:0]      dec_len_ff, dec_len_in;
   logic [tspu_pkg::DIV_W-1:0]          prod_ff, prod_in;
   logic signed [tspu_pkg::CORR_W-1:0]  corr_ff, corr_in;
   logic [tspu_pkg::PEAK_W-1:0]         ramp_ff, ramp_in;
   tspu_pkg::rsp_type                   res_ff, res_in;
   tspu_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Phase advance on a tick
   logic [tspu_pkg::PH_W-1:0]           adv_phase;
   logic [tspu_pkg::TIME_BITS-1:0]      adv_elapsed;
   logic                                adv_fin;

   // Shared multiplier operands
   logic [tspu_pkg::MS_W-1:0]           mul_a;
   logic [tspu_pkg::DVS_W-1:0]          mul_b;
   logic [tspu_pkg::MUL_W-1:0]          mul_p;
   logic [tspu_pkg::DVS_W-1:0]          divisor_sel;

   // Phase length from quotient and minimum
   logic [tspu_pkg::MS_W-1:0]           len_min;
   logic [tspu_pkg::DIV_W-1:0]          len_wide;
   logic [tspu_pkg::TIME_BITS-1:0]      len_sel;

   // Cruise length
   logic [tspu_pkg::DIV_W-1:0]          used_w;
   logic [tspu_pkg::DIV_W-1:0]          total_w;
   logic [tspu_pkg::DIV_W-1:0]          cru_w;
   logic [tspu_pkg::TIME_BITS-1:0]      cru_sel;

   // Heading correction
   logic signed [tspu_pkg::HEAD_W:0]    hd_diff;
   logic signed [tspu_pkg::HPROD_W-1:0] hd_prod;

   // Speed assembly
   logic signed [tspu_pkg::PEAK_W+1:0]  base_s;
   logic signed [tspu_pkg::SUM_W-1:0]   left_w;
   logic signed [tspu_pkg::SUM_W-1:0]   right_w;

   function automatic logic [tspu_pkg::SPD_W-1:0] sat_spd(
      input logic signed [tspu_pkg::SUM_W-1:0] v
   );
      logic signed [tspu_pkg::SUM_W-1:0] hi;
      logic signed [tspu_pkg::SUM_W-1:0] lo;
      hi = tspu_pkg::SUM_W'(32767);
      lo = -tspu_pkg::SUM_W'(32768);
      if (v > hi) begin
         return tspu_pkg::SPD_W'(32767);
      end else if (v < lo) begin
         return tspu_pkg::SPD_W'(32768);
      end else begin
         return v[tspu_pkg::SPD_W-1:0];
      end
   endfunction

   tspu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tspu_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   // Phase transitions, zero-length phases fall straight through
   always_comb begin
      adv_phase   = phase_ff;
      adv_elapsed = elapsed_ff;
      adv_fin     = finished_ff;
      if (adv_phase == tspu_pkg::PH_ACCEL && adv_elapsed >= acc_len_ff) begin
         adv_phase   = tspu_pkg::PH_CRUISE;
         adv_elapsed = '0;
      end
      if (adv_phase == tspu_pkg::PH_CRUISE && adv_elapsed >= cru_len_ff) begin
         adv_phase   = tspu_pkg::PH_DECEL;
         adv_elapsed = '0;
      end
      if (adv_phase == tspu_pkg::PH_DECEL && adv_elapsed >= dec_len_ff) begin
         adv_phase   = tspu_pkg::PH_IDLE;
         adv_elapsed = '0;
         adv_fin     = 1'b1;
      end
   end

   // Operand select for the shared multiplier and divider
   always_comb begin
      if (job_ff == JOB_RAMP) begin
         mul_a       = tspu_pkg::MS_W'(cfg.peak_speed);
         mul_b       = tspu_pkg::DVS_W'(elapsed_ff);
         divisor_sel = (phase_ff == tspu_pkg::PH_ACCEL) ? tspu_pkg::DVS_W'(acc_len_ff)
                                                         : tspu_pkg::DVS_W'(dec_len_ff);
      end else begin
         mul_a       = cfg.total_time_ms;
         mul_b       = (job_ff == JOB_ACC) ? tspu_pkg::DVS_W'(cfg.accel_percent)
                                           : tspu_pkg::DVS_W'(cfg.decel_percent);
         divisor_sel = tspu_pkg::DVS_W'(tspu_pkg::PCT_DIV);
      end
      mul_p = tspu_pkg::MUL_W'(mul_a) * tspu_pkg::MUL_W'(mul_b);
   end

   // Phase length: max with the minimum, then saturate
   always_comb begin
      len_min  = (job_ff == JOB_ACC) ? cfg.min_accel_ms : cfg.min_decel_ms;
      len_wide = (div_sts.quotient > tspu_pkg::DIV_W'(len_min)) ? div_sts.quotient
                                                                : tspu_pkg::DIV_W'(len_min);
      len_sel  = (len_wide > tspu_pkg::DIV_W'(tspu_pkg::TMAX)) ? tspu_pkg::TMAX
                                                               : len_wide[tspu_pkg::TIME_BITS-1:0];
   end

   // Cruise length: remainder of the total, clamped at zero
   always_comb begin
      used_w  = tspu_pkg::DIV_W'(acc_len_ff) + tspu_pkg::DIV_W'(dec_len_ff);
      total_w = tspu_pkg::DIV_W'(cfg.total_time_ms);
      cru_w   = (total_w > used_w) ? (total_w - used_w) : '0;
      cru_sel = (cru_w > tspu_pkg::DIV_W'(tspu_pkg::TMAX)) ? tspu_pkg::TMAX
                                                           : cru_w[tspu_pkg::TIME_BITS-1:0];
   end

   // Heading error times gain; upper bits give the floor of /256
   always_comb begin
      hd_diff = {hd_ff[tspu_pkg::HEAD_W-1], hd_ff}
              - {base_hd_ff[tspu_pkg::HEAD_W-1], base_hd_ff};
      hd_prod = hd_diff * $signed({1'b0, cfg.heading_gain});
   end

   // Base speed, correction, direction
   always_comb begin
      unique case (phase_ff)
         tspu_pkg::PH_ACCEL:  base_s = $signed({2'b00, ramp_ff});
         tspu_pkg::PH_CRUISE: base_s = $signed({2'b00, cfg.peak_speed});
         tspu_pkg::PH_DECEL:  base_s = $signed({2'b00, cfg.peak_speed})
                                     - $signed({2'b00, ramp_ff});
         default:             base_s = '0;
      endcase
      left_w  = tspu_pkg::SUM_W'(base_s) - tspu_pkg::SUM_W'(corr_ff);
      right_w = tspu_pkg::SUM_W'(base_s) + tspu_pkg::SUM_W'(corr_ff);
      if (cfg.reverse) begin
         left_w  = -left_w;
         right_w = -right_w;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      hd_in        = hd_ff;
      base_hd_in   = base_hd_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      finished_in  = finished_ff;
      acc_len_in   = acc_len_ff;
      cru_len_in   = cru_len_ff;
      dec_len_in   = dec_len_ff;
      prod_in      = prod_ff;
      corr_in      = corr_ff;
      ramp_in      = ramp_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      div_cmd.start    = 1'b0;
      div_cmd.dividend = prod_ff;
      div_cmd.divisor  = divisor_sel;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               hd_in = req_data.heading;
               if (req_data.start_req) begin
                  base_hd_in  = req_data.heading;
                  phase_in    = tspu_pkg::PH_ACCEL;
                  elapsed_in  = '0;
                  finished_in = 1'b0;
                  job_in      = JOB_ACC;
                  state_in    = S_MUL;
               end else begin
                  state_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            phase_in    = adv_phase;
            elapsed_in  = adv_elapsed;
            finished_in = adv_fin;
            corr_in     = hd_prod[tspu_pkg::HPROD_W-1:tspu_pkg::GAIN_W];
            job_in      = JOB_RAMP;
            if (adv_phase == tspu_pkg::PH_ACCEL || adv_phase == tspu_pkg::PH_DECEL) begin
               state_in = S_MUL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_MUL: begin
            prod_in  = mul_p[tspu_pkg::DIV_W-1:0];
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            div_cmd.start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (div_sts.done) begin
               unique case (job_ff)
                  JOB_ACC: begin
                     acc_len_in = len_sel;
                     job_in     = JOB_DEC;
                     state_in   = S_MUL;
                  end
                  JOB_DEC: begin
                     dec_len_in = len_sel;
                     state_in   = S_FIN;
                  end
                  default: begin
                     ramp_in  = div_sts.quotient[tspu_pkg::PEAK_W-1:0];
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_FIN: begin
            if (job_ff == JOB_DEC) begin
               // End of a start beat
               cru_len_in       = cru_sel;
               res_in.left_cmd  = '0;
               res_in.right_cmd = '0;
               res_in.phase     = tspu_pkg::PH_ACCEL;
               res_in.done_res  = 1'b0;
            end else if (phase_ff == tspu_pkg::PH_IDLE) begin
               res_in.left_cmd  = '0;
               res_in.right_cmd = '0;
               res_in.phase     = tspu_pkg::PH_IDLE;
               res_in.done_res  = finished_ff;
            end else begin
               res_in.left_cmd  = sat_spd(left_w);
               res_in.right_cmd = sat_spd(right_w);
               res_in.phase     = phase_ff;
               res_in.done_res  = 1'b0;
               if (elapsed_ff < tspu_pkg::TMAX) begin
                  elapsed_in = elapsed_ff + tspu_pkg::TIME_BITS'(1);
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= JOB_ACC;
         base_hd_ff   <= '0;
         phase_ff     <= tspu_pkg::PH_IDLE;
         elapsed_ff   <= '0;
         finished_ff  <= 1'b0;
         acc_len_ff   <= '0;
         cru_len_ff   <= '0;
         dec_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         base_hd_ff   <= base_hd_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         finished_ff  <= finished_in;
         acc_len_ff   <= acc_len_in;
         cru_len_ff   <= cru_len_in;
         dec_len_ff   <= dec_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hd_ff   <= hd_in;
      prod_ff <= prod_in;
      corr_ff <= corr_in;
      ramp_ff <= ramp_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A finished move never reports an active phase
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.phase != tspu_pkg::PH_IDLE))
      else $error("done_res set with active phase");

   // Elapsed time stays within the current ramp phase
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tspu_pkg::PH_ACCEL && state_ff == S_IDLE) |-> elapsed_ff <= acc_len_ff)
      else $error("elapsed beyond accel length");

   a_dec_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tspu_pkg::PH_DECEL && state_ff == S_IDLE) |-> elapsed_ff <= dec_len_ff)
      else $error("elapsed beyond decel length");

   // Ramp quotient never exceeds the peak speed
   a_ramp_peak: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && job_ff == JOB_RAMP &&
       (phase_ff == tspu_pkg::PH_ACCEL || phase_ff == tspu_pkg::PH_DECEL))
      |-> ramp_ff <= cfg.peak_speed)
      else $error("ramp value above peak speed");

   // Divider is only launched when free
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_sts.busy)
      else $error("divider launched while busy");

endmodule
